[hw/rtl/modbus_rtu_slave_frame_engine_unit_defines.svh]
// Assertion macros shared by the frame engine modules.
// Needs no other file; the active forms are left out when SYNTH is defined.
`ifndef MODBUS_RTU_SLAVE_FRAME_ENGINE_UNIT_DEFINES_SVH
`define MODBUS_RTU_SLAVE_FRAME_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTH
// The property must hold at every rising edge outside reset.
`define MBRTU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The condition must never be true at a rising edge outside reset.
`define MBRTU_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MBRTU_ASSERT(lbl, clk, rst_n, prop, msg)
`define MBRTU_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[hw/rtl/mbrtu_pkg.sv]
// Shared constants, types and the CRC-16/MODBUS byte update.
// Used by every module of the frame engine; depends on nothing.
package mbrtu_pkg;

	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [7:0]  FN_READ        = 8'h03;
	localparam logic [7:0]  FN_WRITE       = 8'h06;
	localparam logic [8:0]  LIMIT_RESET    = 9'd250;
	localparam logic [7:0]  STATION_RESET  = 8'd1;
	localparam int          NUM_REGS_DEF   = 256;
	localparam int          MAX_READ_DEF   = 29;

	// One checked request, handed from the receiver to the responder.
	typedef struct packed {
		logic [7:0]  addr;
		logic        is_write;
		logic [15:0] reg_addr;
		logic [15:0] value;
		logic [15:0] crc;
	} cmd_t;

	// Fill state of the request queue.
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Responder status seen by the receiver.
	typedef struct packed {
		logic clearing;
	} back_stat_t;

	// Fold one byte into a CRC-16/MODBUS remainder, LSB first.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[hw/rtl/mbrtu_front.sv]
// Request receiver: collects the 8-byte frame, runs the CRC and checks the request.
// Depends on mbrtu_pkg; pushes accepted requests into the request queue.
module mbrtu_front
	import mbrtu_pkg::*;
#(
	parameter int MAX_READ_COUNT = MAX_READ_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	input  fifo_stat_t  fstat,
	input  back_stat_t  bstat,
	output logic        push,
	output cmd_t        push_cmd
);

	logic [3:0]  pos_q;
	logic [15:0] crc_q;
	logic [8:0]  limit_q;
	logic [7:0]  fb_q [6];
	logic        lo_ok_q;

	logic        accept;
	logic [3:0]  pos;
	logic [15:0] crc_base;
	logic [15:0] reg_addr;
	logic [15:0] value;
	logic        fn_ok;
	logic        crc_ok;
	logic        qty_ok;

	// Input is held off while the register store is cleared or the queue is full.
	assign s_tready = !bstat.clearing && !fstat.full;
	assign accept   = s_tvalid && s_tready;

	// A start flag restarts the frame and the CRC.
	assign pos      = s_tuser[0] ? 4'd0 : pos_q;
	assign crc_base = s_tuser[0] ? CRC_INIT : crc_q;

	// Checks made when the eighth byte arrives.
	assign reg_addr = {fb_q[2], fb_q[3]};
	assign value    = {fb_q[4], fb_q[5]};
	assign fn_ok    = (fb_q[1] == FN_READ) || (fb_q[1] == FN_WRITE);
	assign crc_ok   = lo_ok_q && (s_tdata == crc_base[15:8]);
	assign qty_ok   = (fb_q[1] == FN_WRITE) ||
		((value != 16'd0) && (value <= 16'(MAX_READ_COUNT)));
	assign push     = accept && (pos == 4'd7) && fn_ok && crc_ok && qty_ok &&
		(reg_addr < {7'd0, limit_q});

	assign push_cmd.addr     = fb_q[0];
	assign push_cmd.is_write = (fb_q[1] == FN_WRITE);
	assign push_cmd.reg_addr = reg_addr;
	assign push_cmd.value    = value;
	assign push_cmd.crc      = crc_base;

	// Frame position, running CRC and the limit register.
	// A start byte is always at position 0, so its CRC update starts from the initial value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 4'd8;
			crc_q   <= CRC_INIT;
			limit_q <= LIMIT_RESET;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (accept) begin
				if (!pos[3]) begin
					if (pos < 4'd6) begin
						crc_q <= crc_feed(crc_base, s_tdata);
					end
					pos_q <= 4'(pos + 4'd1);
				end else begin
					pos_q <= pos;
				end
			end
		end
	end

	// Frame bytes and the low CRC byte check.
	always_ff @(posedge clk) begin
		if (accept && !pos[3]) begin
			if (pos < 4'd6) begin
				fb_q[pos[2:0]] <= s_tdata;
			end
			if (pos == 4'd6) begin
				lo_ok_q <= (s_tdata == crc_base[7:0]);
			end
		end
	end

endmodule

[hw/rtl/mbrtu_cmd_fifo.sv]
// Two-entry request queue between the receiver and the responder.
// Depends on mbrtu_pkg and the assertion macro header.
`include "modbus_rtu_slave_frame_engine_unit_defines.svh"
module mbrtu_cmd_fifo
	import mbrtu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmd_t       push_cmd,
	input  logic       pop,
	output cmd_t       head,
	output fifo_stat_t stat
);

	cmd_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign head       = ent_q[rd_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= 2'(cnt_q + 2'd1);
			end else if (pop && !push) begin
				cnt_q <= 2'(cnt_q - 2'd1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	`MBRTU_ASSERT_NEVER(a_fifo_overflow, clk, arst_n, push && stat.full && !pop, "request queue overflow")
	`MBRTU_ASSERT_NEVER(a_fifo_underflow, clk, arst_n, pop && stat.empty, "request queue underflow")

endmodule

[hw/rtl/mbrtu_back.sv]
// Responder: executes queued requests on the holding register store and sends replies.
// Depends on mbrtu_pkg and the assertion macro header.
`include "modbus_rtu_slave_frame_engine_unit_defines.svh"
module mbrtu_back
	import mbrtu_pkg::*;
#(
	parameter int NUM_REGS = NUM_REGS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  fifo_stat_t fstat,
	output logic       pop,
	output back_stat_t bstat,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);

	localparam int AW = $clog2(NUM_REGS);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_ECHO  = 4'd2;
	localparam logic [3:0] ST_HEAD  = 4'd3;
	localparam logic [3:0] ST_RDREQ = 4'd4;
	localparam logic [3:0] ST_HI    = 4'd5;
	localparam logic [3:0] ST_LO    = 4'd6;
	localparam logic [3:0] ST_CRCL  = 4'd7;
	localparam logic [3:0] ST_CRCH  = 4'd8;

	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [7:0]    station_q;
	cmd_t          cmd_q;
	logic [2:0]    idx_q;
	logic [16:0]   cur_q;
	logic [4:0]    rem_q;
	logic [15:0]   crc_q;
	logic          rd_zero_q;
	logic [15:0]   rd_data_q;
	logic [15:0]   regs_mem [NUM_REGS];
	logic          out_valid_q;
	logic [7:0]    out_data_q;
	logic          out_last_q;

	logic          out_free;
	logic          addr_ok;
	logic          emit;
	logic [7:0]    emit_byte;
	logic          emit_last;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic          rd_en;
	logic [15:0]   rd_word;

	assign out_free       = !out_valid_q || m_tready;
	assign addr_ok        = (head.addr == station_q) || (head.addr == 8'd0);
	assign rd_word        = rd_zero_q ? 16'd0 : rd_data_q;
	assign bstat.clearing = (state_q == ST_CLEAR);
	assign m_tvalid       = out_valid_q;
	assign m_tdata        = out_data_q;
	assign m_tlast        = out_last_q;

	// Per-state byte selection and store access.
	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		emit_byte = 8'd0;
		emit_last = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 16'd0;
		rd_en     = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				pop = !fstat.empty;
				if (pop && addr_ok && head.is_write &&
					({1'b0, head.reg_addr} < 17'(NUM_REGS))) begin
					mem_we    = 1'b1;
					mem_waddr = head.reg_addr[AW-1:0];
					mem_wdata = head.value;
				end
			end
			ST_ECHO: begin
				emit      = out_free;
				emit_last = (idx_q == 3'd7);
				case (idx_q)
					3'd0:    emit_byte = cmd_q.addr;
					3'd1:    emit_byte = FN_WRITE;
					3'd2:    emit_byte = cmd_q.reg_addr[15:8];
					3'd3:    emit_byte = cmd_q.reg_addr[7:0];
					3'd4:    emit_byte = cmd_q.value[15:8];
					3'd5:    emit_byte = cmd_q.value[7:0];
					3'd6:    emit_byte = cmd_q.crc[7:0];
					default: emit_byte = cmd_q.crc[15:8];
				endcase
			end
			ST_HEAD: begin
				emit = out_free;
				case (idx_q)
					3'd0:    emit_byte = cmd_q.addr;
					3'd1:    emit_byte = FN_READ;
					default: emit_byte = {2'b00, rem_q, 1'b0};
				endcase
			end
			ST_RDREQ: begin
				rd_en = 1'b1;
			end
			ST_HI: begin
				emit      = out_free;
				emit_byte = rd_word[15:8];
			end
			ST_LO: begin
				emit      = out_free;
				emit_byte = rd_word[7:0];
			end
			ST_CRCL: begin
				emit      = out_free;
				emit_byte = crc_q[7:0];
			end
			ST_CRCH: begin
				emit      = out_free;
				emit_byte = crc_q[15:8];
				emit_last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Sequencer, station address and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			station_q   <= STATION_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= AW'(clr_q + 1'b1);
					if (clr_q == AW'(NUM_REGS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop && addr_ok) begin
						if (head.is_write) begin
							if (head.reg_addr == 16'd0) begin
								station_q <= head.value[7:0];
							end
							state_q <= ST_ECHO;
						end else begin
							state_q <= ST_HEAD;
						end
					end
				end
				ST_ECHO: begin
					if (emit && (idx_q == 3'd7)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_HEAD: begin
					if (emit && (idx_q == 3'd2)) begin
						state_q <= ST_RDREQ;
					end
				end
				ST_RDREQ: begin
					state_q <= ST_HI;
				end
				ST_HI: begin
					if (emit) begin
						state_q <= ST_LO;
					end
				end
				ST_LO: begin
					if (emit) begin
						state_q <= (rem_q == 5'd1) ? ST_CRCL : ST_RDREQ;
					end
				end
				ST_CRCL: begin
					if (emit) begin
						state_q <= ST_CRCH;
					end
				end
				ST_CRCH: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request payload, reply CRC and read cursor.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= emit_byte;
			out_last_q <= emit_last;
		end
		if (state_q == ST_IDLE) begin
			cmd_q <= head;
			idx_q <= 3'd0;
			crc_q <= CRC_INIT;
			cur_q <= {1'b0, head.reg_addr};
			rem_q <= head.value[4:0];
		end
		if (emit) begin
			idx_q <= 3'(idx_q + 3'd1);
			if ((state_q == ST_HEAD) || (state_q == ST_HI) || (state_q == ST_LO)) begin
				crc_q <= crc_feed(crc_q, emit_byte);
			end
			if (state_q == ST_LO) begin
				cur_q <= 17'(cur_q + 17'd1);
				rem_q <= 5'(rem_q - 5'd1);
			end
		end
		if (state_q == ST_RDREQ) begin
			rd_zero_q <= (cur_q >= 17'(NUM_REGS));
		end
	end

	// Holding register store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			regs_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_q <= regs_mem[cur_q[AW-1:0]];
		end
	end

	`MBRTU_ASSERT_NEVER(a_no_reply_in_clear, clk, arst_n, bstat.clearing && out_valid_q, "reply during store clear")
	`MBRTU_ASSERT(a_hi_after_read, clk, arst_n, (state_q == ST_HI) |-> (($past(state_q) == ST_RDREQ) || ($past(state_q) == ST_HI)), "register byte without a store read")

endmodule

[hw/rtl/modbus_rtu_slave_frame_engine_unit.sv]
// Modbus RTU slave frame engine: read and write holding registers over 8-byte request frames.
// A write is answered with an echo of the eight request bytes; a read reply is a three-byte
// head, two data bytes per register and two CRC bytes, with one store read for every register.
// Throughput: one request byte per cycle while the two-entry request queue has room and the
// store is not cleared. Reset: asynchronous; the store is then cleared one entry a cycle,
// all NUM_REGS entries, during which no request byte is taken.
module modbus_rtu_slave_frame_engine_unit
	import mbrtu_pkg::*;
#(
	parameter int NUM_REGS       = NUM_REGS_DEF,
	parameter int MAX_READ_COUNT = MAX_READ_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic [0:0] s_tuser,   // [0] frame_start
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] tx_byte
	output logic       m_tlast,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata
);

	fifo_stat_t fstat;
	back_stat_t bstat;
	logic       push;
	cmd_t       push_cmd;
	logic       pop;
	cmd_t       head;

	// Receiver and request checks.
	mbrtu_front #(
		.MAX_READ_COUNT(MAX_READ_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fstat(fstat),
		.bstat(bstat),
		.push(push),
		.push_cmd(push_cmd)
	);

	// Request queue.
	mbrtu_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.head(head),
		.stat(fstat)
	);

	// Responder and register store.
	mbrtu_back #(
		.NUM_REGS(NUM_REGS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.fstat(fstat),
		.pop(pop),
		.bstat(bstat),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule
